// File: src/ssdg_pkg.sv
// shared types, codes and helpers for the step/direction generator
`default_nettype none
package ssdg_pkg;

  // counter width for step counts
  localparam int unsigned CntW = 24;
  localparam logic [32:0] CntMax = (33'd1 << CntW) - 33'd1;

  // field widths
  localparam int unsigned PerW  = 24;
  localparam int unsigned PosW  = 32;
  localparam int unsigned WidW  = 10;
  localparam int unsigned SetW  = 16;
  localparam int unsigned BoffW = 16;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [PerW-1:0] DefaultPeriod = PerW'(1000);

  // operation codes
  localparam logic [2:0] OpTick   = 3'd0;
  localparam logic [2:0] OpMove   = 3'd1;
  localparam logic [2:0] OpHome   = 3'd2;
  localparam logic [2:0] OpStop   = 3'd3;
  localparam logic [2:0] OpEstop  = 3'd4;
  localparam logic [2:0] OpEnable = 3'd5;

  // motion state codes
  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeMoving = 2'd1;
  localparam logic [1:0] ModeHoming = 2'd2;
  localparam logic [1:0] ModeError  = 2'd3;

  // command status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNotEn   = 2'd1;
  localparam logic [1:0] StBusy    = 2'd2;
  localparam logic [1:0] StNoLimit = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegPulseTicks  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSetupTicks  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHomePeriod  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHomeMax     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBackoff     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInvEnable   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInvLimit    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegHasLimit    = 3'd7;

  typedef struct packed {
    logic [2:0]             op;
    logic signed [23:0]     step_count;
    logic [PerW-1:0]        step_period;
    logic                   enable_on;
    logic                   limit_raw;
  } in_t;

  typedef struct packed {
    logic                   step_pin;
    logic                   dir_pin;
    logic                   en_pin;
    logic [1:0]             motion_state;
    logic signed [PosW-1:0] position;
    logic                   homed_flag;
    logic                   done_pulse;
    logic [1:0]             status;
  } out_t;

  typedef struct packed {
    logic [WidW-1:0]  pulse_ticks;
    logic [SetW-1:0]  setup_ticks;
    logic [PerW-1:0]  homing_period;
    logic [23:0]      homing_max_steps;
    logic [BoffW-1:0] retract_steps;
    logic             invert_enable;
    logic             invert_limit;
    logic             has_limit;
  } cfg_t;

  // saturate a step count to the counter width
  function automatic logic [CntW-1:0] sat_cnt(input logic [23:0] v);
    logic [32:0] wide;
    wide = {9'd0, v};
    if (wide > CntMax) begin
      return CntW'(CntMax);
    end
    return CntW'(wide);
  endfunction

  // effective pulse width: zero acts as one
  function automatic logic [WidW-1:0] pulse_w(input logic [WidW-1:0] w);
    return (w == '0) ? WidW'(1) : w;
  endfunction

  // zero selects the default, then at least twice the pulse width
  function automatic logic [PerW-1:0] clamp_period(input logic [PerW-1:0] p,
                                                   input logic [WidW-1:0] w);
    logic [PerW-1:0] w2;
    logic [PerW-1:0] q;
    w2 = {{(PerW-WidW-1){1'b0}}, w, 1'b0};
    q  = (p == '0) ? DefaultPeriod : p;
    return (q < w2) ? w2 : q;
  endfunction

endpackage
`default_nettype wire

// File: src/stepper_step_dir_generator_unit.sv
// Step/direction pulse generator for one stepper axis.
//
// Channels: in_* carries one item per transfer (a microsecond tick or a
// command), out_* returns exactly one result per item in order, cfg_* writes
// one configuration register per transfer and is always ready.
// An item transfers into an input register; once the output register is free
// or being emptied, it updates the axis state and its result is loaded into
// the output register, which drives out_valid_o. Throughput is one item per
// cycle while the receiver keeps taking results: the whole state update is
// one level of counters and compares on the state registers.
// When the receiver stalls, the result waits in the output register and one
// more item waits in the input register; in_ready_o drops only once both are
// full.
// Reset clears the axis to idle, not enabled, not homed, position zero, and
// loads the register defaults (pulse 5, setup 5, homing period 1000, enable
// inverted). The user must write configuration only while no item is in
// flight; the block itself does not enforce it.
`default_nettype none
module stepper_step_dir_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ssdg_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ssdg_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssdg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ssdg_pkg::CfgDataW-1:0] cfg_data_i
);
  import ssdg_pkg::*;

  cfg_t cfg;
  out_t res;
  in_t  item_q;
  out_t out_q;
  logic item_valid_q;
  logic out_valid_q;
  logic advance;

  assign cfg_ready_o = 1'b1;

  ssdg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // item moves on when the output register is free or being emptied
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  ssdg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // both registers full and stalled: no new transfer may enter
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline full");

  // a stalled result is not overwritten
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

  // done and a command status never come together
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_pulse) |-> (out_q.status == StOk))
    else $error("done reported on a command");

endmodule
`default_nettype wire

// File: src/ssdg_cfg_regs.sv
// configuration register file
`default_nettype none
module ssdg_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ssdg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ssdg_pkg::CfgDataW-1:0] cfg_data_i,
  output ssdg_pkg::cfg_t                cfg_o
);
  import ssdg_pkg::*;

  cfg_t cfg_q;

  // register writes, each truncated to its field width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_ticks      <= WidW'(5);
      cfg_q.setup_ticks      <= SetW'(5);
      cfg_q.homing_period    <= PerW'(1000);
      cfg_q.homing_max_steps <= '0;
      cfg_q.retract_steps    <= '0;
      cfg_q.invert_enable    <= 1'b1;
      cfg_q.invert_limit     <= 1'b0;
      cfg_q.has_limit        <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPulseTicks: cfg_q.pulse_ticks      <= cfg_data_i[WidW-1:0];
        RegSetupTicks: cfg_q.setup_ticks      <= cfg_data_i[SetW-1:0];
        RegHomePeriod: cfg_q.homing_period    <= cfg_data_i[PerW-1:0];
        RegHomeMax:    cfg_q.homing_max_steps <= cfg_data_i[23:0];
        RegBackoff:    cfg_q.retract_steps    <= cfg_data_i[BoffW-1:0];
        RegInvEnable:  cfg_q.invert_enable    <= cfg_data_i[0];
        RegInvLimit:   cfg_q.invert_limit     <= cfg_data_i[0];
        RegHasLimit:   cfg_q.has_limit        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: src/ssdg_core.sv
// motion state and one-item next-state logic
`default_nettype none
module ssdg_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  ssdg_pkg::in_t  item_i,
  input  ssdg_pkg::cfg_t cfg_i,
  output ssdg_pkg::out_t res_o
);
  import ssdg_pkg::*;

  logic [1:0]      mode_q, mode_d;
  logic            phase_q, phase_d;
  logic            enabled_q, enabled_d;
  logic            homed_q, homed_d;
  logic            dir_q, dir_d;
  logic [CntW-1:0] steps_q, steps_d;
  logic [PerW-1:0] period_q, period_d;
  logic [PerW-1:0] tick_q, tick_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            pulse_q, pulse_d;

  logic [WidW-1:0] w;
  logic [PerW-1:0] w_ext;
  logic [PerW-1:0] setup_ext;
  logic            lim;
  logic [CntW-1:0] steps_dec;
  logic [PerW-1:0] gap;
  logic [23:0]     mag;
  logic            done;
  logic [1:0]      status;

  assign w         = pulse_w(cfg_i.pulse_ticks);
  assign w_ext     = PerW'(w);
  assign setup_ext = PerW'(cfg_i.setup_ticks);
  assign lim       = cfg_i.has_limit & (item_i.limit_raw ^ cfg_i.invert_limit);
  assign steps_dec = (steps_q != '0) ? steps_q - CntW'(1) : steps_q;
  // low gap after a pulse, saturating at zero
  assign gap = ({1'b0, period_q} > ({1'b0, w_ext} + 25'd1)) ?
               period_q - w_ext - PerW'(1) : '0;
  assign mag = item_i.step_count[23] ? (~item_i.step_count + 24'd1) : item_i.step_count;

  // next state for one item
  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    enabled_d = enabled_q;
    homed_d   = homed_q;
    dir_d     = dir_q;
    steps_d   = steps_q;
    period_d  = period_q;
    tick_d    = tick_q;
    pos_d     = pos_q;
    pulse_d   = pulse_q;
    done      = 1'b0;
    status    = StOk;
    case (item_i.op)
      OpTick: begin
        if (mode_q == ModeMoving || mode_q == ModeHoming) begin
          if (pulse_q) begin
            if (tick_q > PerW'(1)) begin
              tick_d = tick_q - PerW'(1);
            end else begin
              // end of a step pulse
              pulse_d = 1'b0;
              steps_d = steps_dec;
              if (mode_q == ModeMoving) begin
                pos_d = dir_q ? pos_q + PosW'(1) : pos_q - PosW'(1);
              end
              tick_d = gap;
              if (steps_dec == '0) begin
                if (mode_q == ModeMoving) begin
                  mode_d = ModeIdle;
                  done   = 1'b1;
                end else if (phase_q) begin
                  pos_d   = '0;
                  homed_d = 1'b1;
                  mode_d  = ModeIdle;
                  phase_d = 1'b0;
                  done    = 1'b1;
                end
              end
            end
          end else if (tick_q != '0) begin
            tick_d = tick_q - PerW'(1);
          end else if (mode_q == ModeMoving) begin
            // step start of a move
            if (!enabled_q || steps_q == '0) begin
              mode_d = ModeIdle;
              done   = 1'b1;
            end else if (lim) begin
              steps_d = '0;
              mode_d  = ModeError;
            end else begin
              pulse_d = 1'b1;
              tick_d  = w_ext;
            end
          end else if (!phase_q) begin
            // seeking the limit
            if (lim || steps_q == '0) begin
              phase_d = 1'b1;
              dir_d   = 1'b1;
              steps_d = sat_cnt(24'(cfg_i.retract_steps));
              tick_d  = setup_ext;
            end else begin
              pulse_d = 1'b1;
              tick_d  = w_ext;
            end
          end else if (steps_q == '0) begin
            pos_d   = '0;
            homed_d = 1'b1;
            mode_d  = ModeIdle;
            phase_d = 1'b0;
            done    = 1'b1;
          end else begin
            pulse_d = 1'b1;
            tick_d  = w_ext;
          end
        end
      end
      OpMove: begin
        if (!enabled_q) begin
          status = StNotEn;
        end else if (item_i.step_count != '0) begin
          if (mode_q != ModeIdle) begin
            status = StBusy;
          end else begin
            dir_d    = ~item_i.step_count[23];
            steps_d  = sat_cnt(mag);
            period_d = clamp_period(item_i.step_period, w);
            mode_d   = ModeMoving;
            pulse_d  = 1'b0;
            tick_d   = setup_ext;
          end
        end
      end
      OpHome: begin
        if (!enabled_q) begin
          status = StNotEn;
        end else if (!cfg_i.has_limit) begin
          status = StNoLimit;
        end else if (mode_q == ModeMoving || mode_q == ModeHoming) begin
          status = StBusy;
        end else begin
          phase_d  = 1'b0;
          dir_d    = 1'b0;
          steps_d  = sat_cnt(cfg_i.homing_max_steps);
          period_d = clamp_period(cfg_i.homing_period, w);
          mode_d   = ModeHoming;
          pulse_d  = 1'b0;
          tick_d   = setup_ext;
        end
      end
      OpStop: begin
        steps_d = '0;
        pulse_d = 1'b0;
        tick_d  = '0;
        phase_d = 1'b0;
        mode_d  = ModeIdle;
      end
      OpEstop: begin
        steps_d   = '0;
        pulse_d   = 1'b0;
        tick_d    = '0;
        phase_d   = 1'b0;
        enabled_d = 1'b0;
        mode_d    = ModeError;
      end
      OpEnable: begin
        enabled_d = item_i.enable_on;
      end
      default: ;
    endcase
  end

  // state registers, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeIdle;
      phase_q   <= 1'b0;
      enabled_q <= 1'b0;
      homed_q   <= 1'b0;
      dir_q     <= 1'b0;
      steps_q   <= '0;
      period_q  <= DefaultPeriod;
      tick_q    <= '0;
      pos_q     <= '0;
      pulse_q   <= 1'b0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      enabled_q <= enabled_d;
      homed_q   <= homed_d;
      dir_q     <= dir_d;
      steps_q   <= steps_d;
      period_q  <= period_d;
      tick_q    <= tick_d;
      pos_q     <= pos_d;
      pulse_q   <= pulse_d;
    end
  end

  // result seen after the item
  always_comb begin
    res_o.step_pin     = pulse_d;
    res_o.dir_pin      = dir_d;
    res_o.en_pin       = enabled_d ^ cfg_i.invert_enable;
    res_o.motion_state = mode_d;
    res_o.position     = pos_d;
    res_o.homed_flag   = homed_d;
    res_o.done_pulse   = done;
    res_o.status       = status;
  end

  // no pulse is held outside of motion
  a_idle_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeIdle || mode_q == ModeError) |-> !pulse_q)
    else $error("step pulse high while not in motion");

  // a finished move or homing always lands in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && done) |=> (mode_q == ModeIdle))
    else $error("done without return to idle");

  // the homing back-off phase only exists while homing
  a_phase_homing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (mode_q == ModeHoming))
    else $error("homing phase set outside homing");

endmodule
`default_nettype wire

// File: verif/stepper_step_dir_generator_unit_test.sv
// self-checking testbench for the stepper step/direction generator unit
module stepper_step_dir_generator_unit_test;
  import ssdg_pkg::*;

  // op codes the block treats as no operation
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  stepper_step_dir_generator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } script_row_t;

  // axis model: configuration copy and motion state
  cfg_t        ax_cfg;
  logic [1:0]  ax_mode;
  logic        ax_hphase;
  logic        ax_enabled;
  logic        ax_homed;
  logic        ax_dir;
  logic [23:0] ax_steps;
  logic [23:0] ax_period;
  logic [23:0] ax_timer;
  logic [31:0] ax_pos;
  logic        ax_pulse;

  out_t pending_results[$];
  int   errors;
  int   sent_items;
  int   results_seen;
  bit   gap_free;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5000000;
    $display("stepper_step_dir_generator_unit_test: FAIL");
    $finish;
  end

  // step period after the zero default and the twice-width floor
  function automatic logic [23:0] period_floor(input logic [23:0] p);
    int unsigned w2;
    int unsigned q;
    w2 = 2 * ((ax_cfg.pulse_ticks == '0) ? 1 : ax_cfg.pulse_ticks);
    q  = (p == '0) ? DefaultPeriod : p;
    return 24'((q < w2) ? w2 : q);
  endfunction

  function automatic void halt_axis();
    ax_steps  = '0;
    ax_pulse  = 1'b0;
    ax_timer  = '0;
    ax_hphase = 1'b0;
  endfunction

  function automatic void start_motion(input logic dir, input logic [23:0] steps,
                                       input logic [23:0] period, input logic [1:0] mode);
    ax_dir    = dir;
    ax_steps  = steps;
    ax_period = period;
    ax_mode   = mode;
    ax_pulse  = 1'b0;
    ax_timer  = 24'(ax_cfg.setup_ticks);
  endfunction

  function automatic void complete_homing();
    ax_pos    = '0;
    ax_homed  = 1'b1;
    ax_mode   = ModeIdle;
    ax_hphase = 1'b0;
  endfunction

  // advance the axis model by one item and return the result it gives
  function automatic out_t axis_next(input in_t it);
    int unsigned w;
    logic        lim;
    logic        done;
    logic        fire;
    logic [1:0]  stat;
    logic [24:0] mag;
    out_t        o;
    w    = (ax_cfg.pulse_ticks == '0) ? 1 : ax_cfg.pulse_ticks;
    lim  = ax_cfg.has_limit && (it.limit_raw ^ ax_cfg.invert_limit);
    done = 1'b0;
    fire = 1'b0;
    stat = StOk;
    case (it.op)
      OpTick: begin
        if (ax_mode == ModeMoving || ax_mode == ModeHoming) begin
          if (ax_pulse) begin
            // high time, then end of pulse counts the step
            if (ax_timer > 1) begin
              ax_timer = ax_timer - 24'd1;
            end else begin
              ax_pulse = 1'b0;
              if (ax_steps > 0) ax_steps = ax_steps - 24'd1;
              if (ax_mode == ModeMoving) ax_pos = ax_pos + (ax_dir ? 32'd1 : 32'hFFFF_FFFF);
              ax_timer = (ax_period > w + 1) ? 24'(ax_period - w - 1) : '0;
              if (ax_steps == 0) begin
                if (ax_mode == ModeMoving) begin
                  ax_mode = ModeIdle;
                  done    = 1'b1;
                end else if (ax_hphase) begin
                  complete_homing();
                  done = 1'b1;
                end
              end
            end
          end else if (ax_timer > 0) begin
            ax_timer = ax_timer - 24'd1;
          end else begin
            // timer expired: decide whether the next pulse starts
            fire = 1'b1;
            if (ax_mode == ModeMoving) begin
              if (!ax_enabled || ax_steps == 0) begin
                ax_mode = ModeIdle;
                done    = 1'b1;
                fire    = 1'b0;
              end else if (lim) begin
                ax_steps = '0;
                ax_mode  = ModeError;
                fire     = 1'b0;
              end
            end else if (!ax_hphase) begin
              if (lim || ax_steps == 0) begin
                ax_hphase = 1'b1;
                ax_dir    = 1'b1;
                ax_steps  = 24'(ax_cfg.retract_steps);
                ax_timer  = 24'(ax_cfg.setup_ticks);
                fire      = 1'b0;
              end
            end else if (ax_steps == 0) begin
              complete_homing();
              done = 1'b1;
              fire = 1'b0;
            end
            if (fire) begin
              ax_pulse = 1'b1;
              ax_timer = 24'(w);
            end
          end
        end
      end
      OpMove: begin
        if (!ax_enabled) begin
          stat = StNotEn;
        end else if (it.step_count != 0) begin
          if (ax_mode != ModeIdle) begin
            stat = StBusy;
          end else begin
            mag = it.step_count[23] ? 25'h100_0000 - {1'b0, it.step_count}
                                    : {1'b0, it.step_count};
            start_motion(~it.step_count[23], mag[23:0], period_floor(it.step_period),
                         ModeMoving);
          end
        end
      end
      OpHome: begin
        if (!ax_enabled) begin
          stat = StNotEn;
        end else if (!ax_cfg.has_limit) begin
          stat = StNoLimit;
        end else if (ax_mode == ModeMoving || ax_mode == ModeHoming) begin
          stat = StBusy;
        end else begin
          ax_hphase = 1'b0;
          start_motion(1'b0, ax_cfg.homing_max_steps, period_floor(ax_cfg.homing_period),
                       ModeHoming);
        end
      end
      OpStop: begin
        halt_axis();
        ax_mode = ModeIdle;
      end
      OpEstop: begin
        halt_axis();
        ax_enabled = 1'b0;
        ax_mode    = ModeError;
      end
      OpEnable: ax_enabled = it.enable_on;
      default: ;
    endcase
    o.step_pin     = ax_pulse;
    o.dir_pin      = ax_dir;
    o.en_pin       = ax_enabled ^ ax_cfg.invert_enable;
    o.motion_state = ax_mode;
    o.position     = ax_pos;
    o.homed_flag   = ax_homed;
    o.done_pulse   = done;
    o.status       = stat;
    return o;
  endfunction

  function automatic in_t make_item(input logic [2:0] op, input logic [23:0] cnt,
                                    input logic [23:0] per, input logic en,
                                    input logic lim);
    in_t it;
    it.op          = op;
    it.step_count  = cnt;
    it.step_period = per;
    it.enable_on   = en;
    it.limit_raw   = lim;
    return it;
  endfunction

  function automatic out_t axis_out(input logic st_pin, input logic d_pin, input logic e_pin,
                                    input logic [1:0] ms, input logic [31:0] pos,
                                    input logic hm, input logic dn, input logic [1:0] stat);
    out_t o;
    o.step_pin     = st_pin;
    o.dir_pin      = d_pin;
    o.en_pin       = e_pin;
    o.motion_state = ms;
    o.position     = pos;
    o.homed_flag   = hm;
    o.done_pulse   = dn;
    o.status       = stat;
    return o;
  endfunction

  // offer one item, hold it until the transfer, then record what it should give
  task automatic send_item(input in_t it, input bit typed = 1'b0, input out_t want = '0);
    out_t pred;
    if (!gap_free && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 29);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pred = axis_next(it);
    pending_results.push_back(typed ? want : pred);
    sent_items++;
  endtask

  // stop offering and wait until every pending result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      RegPulseTicks: ax_cfg.pulse_ticks      = data[WidW-1:0];
      RegSetupTicks: ax_cfg.setup_ticks      = data[SetW-1:0];
      RegHomePeriod: ax_cfg.homing_period    = data[PerW-1:0];
      RegHomeMax:    ax_cfg.homing_max_steps = data[23:0];
      RegBackoff:    ax_cfg.retract_steps    = data[BoffW-1:0];
      RegInvEnable:  ax_cfg.invert_enable    = data[0];
      RegInvLimit:   ax_cfg.invert_limit     = data[0];
      default:       ax_cfg.has_limit        = data[0];
    endcase
  endtask

  task automatic load_config(input cfg_t c);
    drain();
    write_reg(RegPulseTicks, CfgDataW'(c.pulse_ticks));
    write_reg(RegSetupTicks, CfgDataW'(c.setup_ticks));
    write_reg(RegHomePeriod, CfgDataW'(c.homing_period));
    write_reg(RegHomeMax, CfgDataW'(c.homing_max_steps));
    write_reg(RegBackoff, CfgDataW'(c.retract_steps));
    write_reg(RegInvEnable, CfgDataW'(c.invert_enable));
    write_reg(RegInvLimit, CfgDataW'(c.invert_limit));
    write_reg(RegHasLimit, CfgDataW'(c.has_limit));
    cfg_valid_i <= 1'b0;
  endtask

  // short pulses and periods so that moves and homing complete quickly
  function automatic cfg_t small_cfg(input bit fitted);
    cfg_t c;
    c.pulse_ticks      = WidW'($urandom_range(1, 3));
    c.setup_ticks      = SetW'($urandom_range(0, 6));
    c.homing_period    = PerW'($urandom_range(2, 12));
    c.homing_max_steps = 24'($urandom_range(0, 20));
    c.retract_steps    = BoffW'($urandom_range(0, 6));
    c.invert_enable    = 1'($urandom_range(0, 1));
    c.invert_limit     = 1'($urandom_range(0, 1));
    c.has_limit        = fitted;
    return c;
  endfunction

  // ticks while the axis is in motion, with a rare command thrown in
  task automatic run_ticks(input int budget, input int lim_pct);
    in_t  it;
    logic hit;
    while ((ax_mode == ModeMoving || ax_mode == ModeHoming) && budget > 0) begin
      budget--;
      if ($urandom_range(0, 99) < 3) begin
        case ($urandom_range(0, 4))
          0: it = make_item(OpStop, 24'($urandom), 24'($urandom), 1'b0, 1'b0);
          1: it = make_item(OpEstop, 24'($urandom), 24'($urandom), 1'b1, 1'b0);
          2: it = make_item(OpEnable, 24'($urandom), 24'($urandom),
                            1'($urandom_range(0, 1)), 1'b0);
          3: it = make_item(OpMove, 24'($urandom), 24'($urandom), 1'b0, 1'b1);
          default: it = make_item(OpHome, 24'($urandom), 24'($urandom), 1'b0, 1'b1);
        endcase
      end else begin
        hit = ($urandom_range(0, 99) < lim_pct);
        it  = make_item(OpTick, 24'($urandom), 24'($urandom), 1'($urandom_range(0, 1)),
                        hit ^ ax_cfg.invert_limit);
      end
      send_item(it);
    end
  endtask

  // random traffic: mostly complete moves and homing runs, some noise
  task automatic run_phase(input int target, input bit no_gaps);
    int                 base;
    int                 pick;
    int                 left;
    logic signed [23:0] cnt;
    logic [23:0]        per;
    base     = sent_items;
    gap_free = no_gaps;
    while (sent_items - base < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if (ax_mode != ModeIdle) send_item(make_item(OpStop, '0, '0, 1'b0, 1'b0));
        if (!ax_enabled) send_item(make_item(OpEnable, '0, '0, 1'b1, 1'b0));
        cnt = 24'($urandom_range(1, 6));
        if ($urandom_range(0, 1)) cnt = -cnt;
        if ($urandom_range(0, 9) == 0) cnt = 24'($urandom);
        per = 24'($urandom_range(1, 12));
        case ($urandom_range(0, 9))
          0: per = '0;
          1: per = 24'($urandom);
          default: ;
        endcase
        send_item(make_item(OpMove, cnt, per, 1'($urandom_range(0, 1)), 1'b0));
        left = target - (sent_items - base);
        run_ticks((left < 200) ? left : 200, 2);
        if (ax_mode == ModeMoving) send_item(make_item(OpStop, '0, '0, 1'b0, 1'b0));
      end else if (pick < 70) begin
        if (ax_mode == ModeMoving || ax_mode == ModeHoming) begin
          send_item(make_item(OpStop, '0, '0, 1'b0, 1'b0));
        end
        if (!ax_enabled && $urandom_range(0, 9) != 0) begin
          send_item(make_item(OpEnable, '0, '0, 1'b1, 1'b0));
        end
        send_item(make_item(OpHome, 24'($urandom), 24'($urandom), 1'b0, 1'b0));
        left = target - (sent_items - base);
        run_ticks((left < 250) ? left : 250, 8);
        if (ax_mode == ModeHoming) send_item(make_item(OpStop, '0, '0, 1'b0, 1'b0));
      end else begin
        send_item(make_item(3'($urandom_range(0, 7)), 24'($urandom), 24'($urandom),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end
    end
    gap_free = 1'b0;
  endtask

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result side: random back-pressure, one long hold, compare each transfer
  initial begin
    int   hold_left;
    bit   held_once;
    out_t want;
    out_t got;
    hold_left   = 0;
    held_once   = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        results_seen++;
        got = out_data_o;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          field_check("step_pin", want.step_pin, got.step_pin);
          field_check("dir_pin", want.dir_pin, got.dir_pin);
          field_check("en_pin", want.en_pin, got.en_pin);
          field_check("motion_state", want.motion_state, got.motion_state);
          field_check("position", want.position, got.position);
          field_check("homed_flag", want.homed_flag, got.homed_flag);
          field_check("done_pulse", want.done_pulse, got.done_pulse);
          field_check("status", want.status, got.status);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held_once && results_seen >= 120 && in_valid_i) begin
        // long hold while items keep coming, so the input side backs up
        held_once   = 1'b1;
        hold_left   = 60;
        out_ready_i <= 1'b0;
      end else if (results_seen >= 300 && results_seen < 420) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 29);
      end
    end
  end

  // stimulus
  initial begin
    script_row_t script[$];
    cfg_t        c;
    int          wait_cycles;
    errors       = 0;
    sent_items   = 0;
    results_seen = 0;
    gap_free     = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;

    // axis model after reset
    ax_cfg.pulse_ticks      = WidW'(5);
    ax_cfg.setup_ticks      = SetW'(5);
    ax_cfg.homing_period    = PerW'(1000);
    ax_cfg.homing_max_steps = '0;
    ax_cfg.retract_steps    = '0;
    ax_cfg.invert_enable    = 1'b1;
    ax_cfg.invert_limit     = 1'b0;
    ax_cfg.has_limit        = 1'b0;
    ax_mode    = ModeIdle;
    ax_hphase  = 1'b0;
    ax_enabled = 1'b0;
    ax_homed   = 1'b0;
    ax_dir     = 1'b0;
    ax_steps   = '0;
    ax_period  = DefaultPeriod;
    ax_timer   = '0;
    ax_pos     = '0;
    ax_pulse   = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script on reset defaults: refusals, no-ops, extreme moves, stops
    script.push_back('{make_item(OpTick, '0, '0, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b1, ModeIdle, 32'd0, 1'b0, 1'b0, StOk)});
    script.push_back('{make_item(OpMove, 24'h7F_FFFF, '0, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b1, ModeIdle, 32'd0, 1'b0, 1'b0, StNotEn)});
    script.push_back('{make_item(OpHome, '0, '0, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b1, ModeIdle, 32'd0, 1'b0, 1'b0, StNotEn)});
    script.push_back('{make_item(OpEnable, '0, '0, 1'b1, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b0, ModeIdle, 32'd0, 1'b0, 1'b0, StOk)});
    script.push_back('{make_item(OpHome, '0, '0, 1'b0, 1'b1), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b0, ModeIdle, 32'd0, 1'b0, 1'b0, StNoLimit)});
    script.push_back('{make_item(OpMove, '0, 24'd7, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b0, ModeIdle, 32'd0, 1'b0, 1'b0, StOk)});
    script.push_back('{make_item(OpSpare6, 24'h00_0003, 24'd3, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b0, ModeIdle, 32'd0, 1'b0, 1'b0, StOk)});
    script.push_back('{make_item(OpSpare7, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b0, ModeIdle, 32'd0, 1'b0, 1'b0, StOk)});
    script.push_back('{make_item(OpMove, 24'h7F_FFFF, '0, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b1, 1'b0, ModeMoving, 32'd0, 1'b0, 1'b0, StOk)});
    script.push_back('{make_item(OpMove, 24'd1, 24'd20, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b1, 1'b0, ModeMoving, 32'd0, 1'b0, 1'b0, StBusy)});
    // direction setup runs out and the first pulse rises
    for (int k = 0; k < 6; k++) begin
      script.push_back('{make_item(OpTick, '0, '0, 1'b0, 1'(k)), 1'b0, '0});
    end
    script.push_back('{make_item(OpStop, '0, '0, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b1, 1'b0, ModeIdle, 32'd0, 1'b0, 1'b0, StOk)});
    script.push_back('{make_item(OpMove, 24'h80_0000, 24'hFF_FFFF, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b0, ModeMoving, 32'd0, 1'b0, 1'b0, StOk)});
    script.push_back('{make_item(OpEstop, '0, '0, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b1, ModeError, 32'd0, 1'b0, 1'b0, StOk)});
    script.push_back('{make_item(OpTick, '0, '0, 1'b0, 1'b1), 1'b0, '0});
    script.push_back('{make_item(OpMove, 24'd3, 24'd9, 1'b0, 1'b0), 1'b1,
                       axis_out(1'b0, 1'b0, 1'b1, ModeError, 32'd0, 1'b0, 1'b0, StNotEn)});
    script.push_back('{make_item(OpEnable, '0, '0, 1'b1, 1'b0), 1'b0, '0});
    script.push_back('{make_item(OpMove, 24'd3, 24'd9, 1'b0, 1'b0), 1'b0, '0});
    script.push_back('{make_item(OpStop, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    foreach (script[i]) send_item(script[i].item, script[i].typed, script[i].want);

    // reset defaults, no limit switch fitted
    run_phase(80, 1'b0);

    // short timing with a limit switch, no sender gaps
    load_config(small_cfg(1'b1));
    run_phase(160, 1'b1);

    // smallest settings, zero pulse width acting as one
    c.pulse_ticks      = '0;
    c.setup_ticks      = '0;
    c.homing_period    = PerW'(2);
    c.homing_max_steps = '0;
    c.retract_steps    = '0;
    c.invert_enable    = 1'b0;
    c.invert_limit     = 1'b1;
    c.has_limit        = 1'b1;
    load_config(c);
    run_phase(60, 1'b0);

    load_config(small_cfg(1'($urandom_range(0, 1))));
    run_phase(150, 1'b0);

    // largest settings
    c.pulse_ticks      = '1;
    c.setup_ticks      = '1;
    c.homing_period    = '1;
    c.homing_max_steps = '1;
    c.retract_steps    = '1;
    c.invert_enable    = 1'b1;
    c.invert_limit     = 1'b1;
    c.has_limit        = 1'b1;
    load_config(c);
    run_phase(30, 1'b0);

    // let the last results come back
    in_valid_i <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 20000 && pending_results.size() != 0; wait_cycles++) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               pending_results.size());
    end
    if (errors == 0) begin
      $display("stepper_step_dir_generator_unit_test: PASS");
    end else begin
      $display("stepper_step_dir_generator_unit_test: FAIL");
    end
    $finish;
  end

endmodule
